// ----- rtl/mandelbrot_escape_time_unit_defines.svh -----
// Assertion macros used by the escape-time unit sequencer RTL.
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define MBET_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbet: implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define MBET_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbet: next-cycle check failed");
`else
`define MBET_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MBET_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/mbet_pkg.sv -----
// Types, constants and the partial-product schedule of the escape-time unit.
`timescale 1ns / 1ps
`default_nettype none
package mbet_pkg;

    localparam int FRAC_BITS_DEF = 60;
    localparam int Z_W           = 64;
    localparam int ACC_W         = 128;
    localparam int MUL_W         = 32;
    localparam int CNT_W         = 16;
    localparam int NUM_PP        = 10;
    localparam int PP_CNT_W      = 4;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 16'd256;
    localparam logic [Z_W-1:0]   Z_MAX       = 64'h7fff_ffff_ffff_ffff;
    localparam logic [Z_W-1:0]   Z_MIN       = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_CLR   = 3'd2,
        OP_ACC   = 3'd3,
        OP_CHECK = 3'd4,
        OP_DIFF  = 3'd5,
        OP_UPR   = 3'd6,
        OP_UPI   = 3'd7
    } op_t;

    // 32-bit halves of |zr| and |zi| fed to the multiplier.
    typedef enum logic [1:0] {
        H_RL = 2'd0,
        H_RH = 2'd1,
        H_IL = 2'd2,
        H_IH = 2'd3
    } half_t;

    // A: zr^2, later zr^2 - zi^2. B: zi^2. C: signed zr*zi.
    typedef enum logic [1:0] {
        ACC_A = 2'd0,
        ACC_B = 2'd1,
        ACC_C = 2'd2
    } acc_sel_t;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_32 = 2'd1,
        SH_33 = 2'd2,
        SH_64 = 2'd3
    } shift_t;

    typedef struct packed {
        half_t    a_sel;
        half_t    b_sel;
        acc_sel_t acc_sel;
        shift_t   shift;
    } pp_t;

    typedef struct packed {
        op_t      op;
        half_t    mul_a;
        half_t    mul_b;
        acc_sel_t acc_sel;
        shift_t   acc_shift;
    } ctrl_t;

    typedef struct packed {
        logic mag_escape;
        logic sum_escape;
    } stat_t;

    // Ten 32x32 partial products build zr^2, zi^2 and zr*zi.
    function automatic pp_t pp_entry(input logic [PP_CNT_W-1:0] idx);
        pp_t e;
        e = '{a_sel: H_RL, b_sel: H_RL, acc_sel: ACC_A, shift: SH_0};
        case (idx)
            4'd0: e = '{a_sel: H_RL, b_sel: H_RL, acc_sel: ACC_A, shift: SH_0};
            4'd1: e = '{a_sel: H_RL, b_sel: H_RH, acc_sel: ACC_A, shift: SH_33};
            4'd2: e = '{a_sel: H_RH, b_sel: H_RH, acc_sel: ACC_A, shift: SH_64};
            4'd3: e = '{a_sel: H_IL, b_sel: H_IL, acc_sel: ACC_B, shift: SH_0};
            4'd4: e = '{a_sel: H_IL, b_sel: H_IH, acc_sel: ACC_B, shift: SH_33};
            4'd5: e = '{a_sel: H_IH, b_sel: H_IH, acc_sel: ACC_B, shift: SH_64};
            4'd6: e = '{a_sel: H_RL, b_sel: H_IL, acc_sel: ACC_C, shift: SH_0};
            4'd7: e = '{a_sel: H_RL, b_sel: H_IH, acc_sel: ACC_C, shift: SH_32};
            4'd8: e = '{a_sel: H_RH, b_sel: H_IL, acc_sel: ACC_C, shift: SH_32};
            4'd9: e = '{a_sel: H_RH, b_sel: H_IH, acc_sel: ACC_C, shift: SH_64};
            default: e = '{a_sel: H_RL, b_sel: H_RL, acc_sel: ACC_A, shift: SH_0};
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/mbet_mul32.sv -----
// Shared 32x32 unsigned multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module mbet_mul32 (
    input  wire logic                          clk,
    input  wire logic [mbet_pkg::MUL_W-1:0]    a,
    input  wire logic [mbet_pkg::MUL_W-1:0]    b,
    output logic      [2*mbet_pkg::MUL_W-1:0]  prod
);
    import mbet_pkg::*;

    logic [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

// ----- rtl/mbet_dpath.sv -----
// Escape-time datapath: z and c registers, accumulators and the shared wide adder.
`timescale 1ns / 1ps
`default_nettype none
module mbet_dpath #(
    parameter int FRAC_BITS = mbet_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire mbet_pkg::ctrl_t               ctrl,
    input  wire logic [mbet_pkg::Z_W-1:0]      in_real,
    input  wire logic [mbet_pkg::Z_W-1:0]      in_imag,
    input  wire logic [2*mbet_pkg::MUL_W-1:0]  prod,
    output logic      [mbet_pkg::MUL_W-1:0]    mul_a,
    output logic      [mbet_pkg::MUL_W-1:0]    mul_b,
    output mbet_pkg::stat_t                    stat,
    output logic      [mbet_pkg::Z_W-1:0]      z_real,
    output logic      [mbet_pkg::Z_W-1:0]      z_imag,
    output logic      [mbet_pkg::Z_W-1:0]      c_real,
    output logic      [mbet_pkg::Z_W-1:0]      c_imag
);
    import mbet_pkg::*;

    localparam logic [ACC_W-1:0] FOUR = ACC_W'(1) << (2 * FRAC_BITS + 2);
    localparam logic [Z_W-1:0]   TWO  = Z_W'(1) << (FRAC_BITS + 1);

    logic        [Z_W-1:0]   cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [ACC_W-1:0] acc_a_reg, acc_b_reg, acc_c_reg;

    logic [Z_W-1:0]   mag_r, mag_i;
    logic [ACC_W-1:0] pp_shifted;
    logic [ACC_W-1:0] add_a, add_b, add_sum;
    logic             add_sub;
    logic             cross_neg;
    logic             fits;
    logic [Z_W-1:0]   sat_sum;

    assign mag_r     = zr_reg[Z_W-1] ? (~zr_reg + 1'b1) : zr_reg;
    assign mag_i     = zi_reg[Z_W-1] ? (~zi_reg + 1'b1) : zi_reg;
    assign cross_neg = zr_reg[Z_W-1] ^ zi_reg[Z_W-1];

    function automatic logic [MUL_W-1:0] pick_half(input half_t sel,
                                                   input logic [Z_W-1:0] mr,
                                                   input logic [Z_W-1:0] mi);
        logic [MUL_W-1:0] h;
        h = '0;
        case (sel)
            H_RL:    h = mr[MUL_W-1:0];
            H_RH:    h = mr[2*MUL_W-1:MUL_W];
            H_IL:    h = mi[MUL_W-1:0];
            H_IH:    h = mi[2*MUL_W-1:MUL_W];
            default: h = '0;
        endcase
        return h;
    endfunction

    assign mul_a = pick_half(ctrl.mul_a, mag_r, mag_i);
    assign mul_b = pick_half(ctrl.mul_b, mag_r, mag_i);

    always_comb
    begin
        pp_shifted = '0;
        case (ctrl.acc_shift)
            SH_0:    pp_shifted = {{(ACC_W-2*MUL_W){1'b0}}, prod};
            SH_32:   pp_shifted = {{(ACC_W-2*MUL_W){1'b0}}, prod} << MUL_W;
            SH_33:   pp_shifted = {{(ACC_W-2*MUL_W){1'b0}}, prod} << (MUL_W + 1);
            SH_64:   pp_shifted = {{(ACC_W-2*MUL_W){1'b0}}, prod} << (2 * MUL_W);
            default: pp_shifted = '0;
        endcase
    end

    // One wide adder serves every arithmetic step of an iteration.
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (ctrl.op)
            OP_ACC:
            begin
                unique case (ctrl.acc_sel)
                    ACC_A:   add_a = acc_a_reg;
                    ACC_B:   add_a = acc_b_reg;
                    ACC_C:   add_a = acc_c_reg;
                    default: add_a = '0;
                endcase
                add_b   = pp_shifted;
                add_sub = (ctrl.acc_sel == ACC_C) && cross_neg;
            end
            OP_CHECK:
            begin
                add_a = acc_a_reg;
                add_b = acc_b_reg;
            end
            OP_DIFF:
            begin
                add_a   = acc_a_reg;
                add_b   = acc_b_reg;
                add_sub = 1'b1;
            end
            OP_UPR:
            begin
                add_a = ACC_W'(acc_a_reg >>> FRAC_BITS);
                add_b = {{(ACC_W-Z_W){cr_reg[Z_W-1]}}, cr_reg};
            end
            OP_UPI:
            begin
                add_a = ACC_W'(acc_c_reg >>> (FRAC_BITS - 1));
                add_b = {{(ACC_W-Z_W){ci_reg[Z_W-1]}}, ci_reg};
            end
            default:
            begin
                add_a   = '0;
                add_b   = '0;
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(ACC_W-1){1'b0}}, add_sub};

    // Clamp to the signed 64-bit range when the upper bits are not a sign fill.
    assign fits    = (add_sum[ACC_W-1:Z_W-1] == '0) || (add_sum[ACC_W-1:Z_W-1] == '1);
    assign sat_sum = fits ? add_sum[Z_W-1:0] : (add_sum[ACC_W-1] ? Z_MIN : Z_MAX);

    assign stat.mag_escape = (mag_r >= TWO) || (mag_i >= TWO);
    assign stat.sum_escape = (add_sum >= FOUR);

    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            OP_LOAD:
            begin
                cr_reg <= in_real;
                ci_reg <= in_imag;
                zr_reg <= '0;
                zi_reg <= '0;
            end
            OP_CLR:
            begin
                acc_a_reg <= '0;
                acc_b_reg <= '0;
                acc_c_reg <= '0;
            end
            OP_ACC:
            begin
                unique case (ctrl.acc_sel)
                    ACC_A:   acc_a_reg <= add_sum;
                    ACC_B:   acc_b_reg <= add_sum;
                    ACC_C:   acc_c_reg <= add_sum;
                    default: acc_a_reg <= acc_a_reg;
                endcase
            end
            OP_DIFF: acc_a_reg <= add_sum;
            OP_UPR:  zr_reg    <= sat_sum;
            OP_UPI:  zi_reg    <= sat_sum;
            default: zr_reg    <= zr_reg;
        endcase
    end

    assign z_real = zr_reg;
    assign z_imag = zi_reg;
    assign c_real = cr_reg;
    assign c_imag = ci_reg;

endmodule
`default_nettype wire

// ----- rtl/mbet_seq.sv -----
// Sequencer that steps the shared multiplier and adder through each iteration.
`timescale 1ns / 1ps
`default_nettype none
`include "mandelbrot_escape_time_unit_defines.svh"
module mbet_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_fire,
    input  wire logic [mbet_pkg::CNT_W-1:0]  limit,
    input  wire logic                        out_free,
    input  wire mbet_pkg::stat_t             stat,
    output mbet_pkg::ctrl_t                  ctrl,
    output logic                             in_ready,
    output logic                             done_load,
    output logic                             escaped,
    output logic      [mbet_pkg::CNT_W-1:0]  count
);
    import mbet_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_TEST  = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_CHECK = 8'b0000_1000,
        S_DIFF  = 8'b0001_0000,
        S_UPR   = 8'b0010_0000,
        S_UPI   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    step_reg, step_next;
    logic [PP_CNT_W-1:0] pp_cnt_reg, pp_cnt_next;
    logic                escaped_reg, escaped_next;
    pp_t                 pp_issue, pp_accum;

    assign pp_issue = pp_entry(pp_cnt_reg);
    assign pp_accum = pp_entry(pp_cnt_reg - 1'b1);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        pp_cnt_next    = pp_cnt_reg;
        escaped_next   = escaped_reg;
        ctrl.op        = OP_NONE;
        ctrl.mul_a     = pp_issue.a_sel;
        ctrl.mul_b     = pp_issue.b_sel;
        ctrl.acc_sel   = pp_accum.acc_sel;
        ctrl.acc_shift = pp_accum.shift;
        done_load      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ctrl.op    = OP_LOAD;
                    step_next  = '0;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (step_reg == limit)
                begin
                    escaped_next = 1'b0;
                    state_next   = S_DONE;
                end
                else if (stat.mag_escape)
                begin
                    escaped_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    ctrl.op     = OP_CLR;
                    pp_cnt_next = '0;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                // Issue product n while folding product n-1 into its accumulator.
                if (pp_cnt_reg != '0)
                begin
                    ctrl.op = OP_ACC;
                end
                if (pp_cnt_reg == PP_CNT_W'(NUM_PP))
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    pp_cnt_next = pp_cnt_reg + 1'b1;
                end
            end
            S_CHECK:
            begin
                ctrl.op = OP_CHECK;
                if (stat.sum_escape)
                begin
                    escaped_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                ctrl.op    = OP_DIFF;
                state_next = S_UPR;
            end
            S_UPR:
            begin
                ctrl.op    = OP_UPR;
                state_next = S_UPI;
            end
            S_UPI:
            begin
                ctrl.op    = OP_UPI;
                step_next  = step_reg + 1'b1;
                state_next = S_TEST;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    done_load  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            pp_cnt_reg  <= '0;
            escaped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            pp_cnt_reg  <= pp_cnt_next;
            escaped_reg <= escaped_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign escaped  = escaped_reg;
    assign count    = step_reg;

    `MBET_ASSERT_IMP(a_pp_range, clk, rst_n, state_reg == S_MUL, pp_cnt_reg <= PP_CNT_W'(NUM_PP))
    `MBET_ASSERT_IMP(a_step_bound, clk, rst_n, state_reg == S_TEST, step_reg <= limit)
    `MBET_ASSERT_NXT(a_check_next, clk, rst_n, (state_reg == S_CHECK) && !stat.sum_escape, state_reg == S_DIFF)
    `MBET_ASSERT_NXT(a_fire_test, clk, rst_n, in_fire, (state_reg == S_TEST) && (step_reg == '0))

endmodule
`default_nettype wire

// ----- rtl/mandelbrot_escape_time_unit.sv -----
// Top level of the Mandelbrot escape-time unit: ports, limit register, result register.
//
// Usage:
//   Input stream (s_axis_*): one beat carries a point c as two signed fixed-point
//   words with FRAC_BITS fraction bits. Output stream (m_axis_*): one beat per point
//   with the escape step count, the escape flag in tuser and the final z (or c when
//   the point stays bounded). cfg_we/cfg_wdata load the iteration limit; write it
//   only while no point is in flight.
//   Timing: one point is worked at a time. Each iteration runs the limit and
//   magnitude test, ten partial products on the shared 32x32 multiplier, whose
//   product is registered, and four steps on the wide adder (squared-magnitude
//   test, difference, two updates). An escape is caught by the magnitude test or
//   by the squared-magnitude test. s_axis_tready is high only while the
//   sequencer is idle.
//   A finished beat waits in the output register; the next point is accepted at
//   once. If the receiver stalls, a second finished point holds in the sequencer
//   until the output register frees up.
//   Reset: clears the sequencer and output valid and restores the limit to 256.
`timescale 1ns / 1ps
`default_nettype none
module mandelbrot_escape_time_unit #(
    parameter int FRAC_BITS = mbet_pkg::FRAC_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // Limit register write port
    input  wire logic           cfg_we,
    input  wire logic [15:0]    cfg_wdata,   // iteration_limit
    // Point input stream
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [127:0]   s_axis_tdata,  // [63:0] point_real, [127:64] point_imag
    // Result output stream
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic      [143:0]   m_axis_tdata,  // [15:0] escape_count, [79:16] final_real,
                                               // [143:80] final_imag
    output logic      [0:0]     m_axis_tuser   // [0] did_escape
);
    import mbet_pkg::*;

    logic [CNT_W-1:0]   limit_reg;
    logic               m_valid_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               escaped_reg;
    logic [Z_W-1:0]     final_real_reg, final_imag_reg;

    ctrl_t              ctrl;
    stat_t              stat;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] prod;
    logic [Z_W-1:0]     z_real, z_imag, c_real, c_imag;
    logic               in_fire, out_free, done_load, seq_escaped;
    logic [CNT_W-1:0]   seq_count;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    // Hold the iteration limit; the user must keep writes between points, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    mbet_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .limit     (limit_reg),
        .out_free  (out_free),
        .stat      (stat),
        .ctrl      (ctrl),
        .in_ready  (s_axis_tready),
        .done_load (done_load),
        .escaped   (seq_escaped),
        .count     (seq_count)
    );

    mbet_mul32 u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    mbet_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk     (clk),
        .ctrl    (ctrl),
        .in_real (s_axis_tdata[Z_W-1:0]),
        .in_imag (s_axis_tdata[2*Z_W-1:Z_W]),
        .prod    (prod),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .stat    (stat),
        .z_real  (z_real),
        .z_imag  (z_imag),
        .c_real  (c_real),
        .c_imag  (c_imag)
    );

    // Output valid: set on a finished point, drop when the beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (done_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload: z at escape, or c echoed for a bounded point.
    always_ff @(posedge clk)
    begin
        if (done_load)
        begin
            count_reg      <= seq_count;
            escaped_reg    <= seq_escaped;
            final_real_reg <= seq_escaped ? z_real : c_real;
            final_imag_reg <= seq_escaped ? z_imag : c_imag;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = {final_imag_reg, final_real_reg, count_reg};
    assign m_axis_tuser[0] = escaped_reg;

endmodule
`default_nettype wire
